@@ design/point_projection_zbuffer_macros.svh @@
// Assertion macros for the point projection checker.
// The including module must provide clk and rst_n.
`ifndef POINT_PROJECTION_ZBUFFER_MACROS_SVH
`define POINT_PROJECTION_ZBUFFER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PPZ_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ppz check failed");

// Next-cycle implication, disabled during reset.
`define PPZ_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ppz check failed");

`endif

@@ design/ppz_pkg.sv @@
// Shared constants, types and the glyph lookup for the point projection block.
// No dependencies.
package ppz_pkg;

  localparam int MAX_PIXELS = 8192;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int CELL_W     = 17;
  localparam int INV_W      = 32;
  localparam int POS_W      = 24;
  localparam int PROD_W     = 64;
  localparam int GAIN_W     = 70;
  localparam int MAG_W      = 61;
  localparam int SUM_W      = 63;
  localparam int FRAC_SH    = 40;

  // Configuration register indexes.
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_OFFSET = 3'd2;
  localparam logic [2:0] REG_CENTY  = 3'd3;
  localparam logic [2:0] REG_SHADE  = 3'd4;
  localparam logic [2:0] REG_COLOUR = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_PROJ, ST_CELL, ST_READ, ST_TEST, ST_OUT
  } state_t;

  // One access to the depth memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [INV_W-1:0]  wdata;
  } mem_req_t;

  localparam logic [7:0] SHADE_RAMP [12] = '{
    8'h2E, 8'h2C, 8'h2D, 8'h7E, 8'h3A, 8'h3B,
    8'h3D, 8'h21, 8'h2A, 8'h23, 8'h24, 8'h40
  };

  // Non-positive levels give a dot, levels past the ramp end saturate.
  function automatic logic [7:0] glyph_of(input logic signed [4:0] level);
    logic [7:0] g;
    if (level <= 5'sd0) begin
      g = SHADE_RAMP[0];
    end else if (level > 5'sd11) begin
      g = SHADE_RAMP[11];
    end else begin
      g = SHADE_RAMP[level[3:0]];
    end
    return g;
  endfunction

endpackage

@@ design/ppz_recip.sv @@
// Iterative restoring divider that forms floor(2^40 / denom), saturated to 32 bits.
// Depends on ppz_pkg.
module ppz_recip (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [31:0]               denom,
  output logic                      done,
  output logic [ppz_pkg::INV_W-1:0] inv
);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [5:0]                step_r, step_nxt;
  logic [31:0]               d_r, d_nxt;
  logic [31:0]               rem_r, rem_nxt;
  logic [ppz_pkg::INV_W-1:0] q_r, q_nxt;
  logic [32:0]               shifted;
  logic                      ge;

  // One quotient bit per cycle; the dividend has a single one at bit 40.
  always_comb begin
    shifted  = {rem_r, step_r == 6'd40};
    ge       = shifted >= {1'b0, d_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      d_nxt = denom;
      if (denom <= 32'd256) begin
        q_nxt    = '1;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        step_nxt = 6'd40;
        rem_nxt  = '0;
        q_nxt    = '0;
      end
    end else if (busy_r) begin
      // The remainder stays below the divisor, so 32 bits hold it.
      rem_nxt = ge ? 32'(shifted - {1'b0, d_r}) : shifted[31:0];
      q_nxt   = {q_r[ppz_pkg::INV_W-2:0], ge};
      if (step_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    d_r    <= d_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
  end

  assign done = done_r;
  assign inv  = q_r;

endmodule

@@ design/ppz_project.sv @@
// Projection sequencer: one shared 32x32 multiplier, x axis then y axis, four steps each.
// Depends on ppz_pkg.
module ppz_project (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ppz_pkg::INV_W-1:0]        inv,
  input  logic signed [31:0]               coord_x,
  input  logic signed [31:0]               coord_y,
  input  logic [8:0]                       width,
  input  logic [23:0]                      center_y,
  output logic                             done,
  output logic signed [ppz_pkg::POS_W-1:0] col,
  output logic signed [ppz_pkg::POS_W-1:0] row
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic                              axis_r, axis_nxt;
  logic [1:0]                        step_r, step_nxt;
  logic                              neg_r, neg_nxt;
  logic [ppz_pkg::PROD_W-1:0]        prod_r, prod_nxt;
  logic [ppz_pkg::MAG_W-1:0]         mag_r, mag_nxt;
  logic signed [ppz_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [ppz_pkg::POS_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic signed [31:0]                coord;
  logic [31:0]                       coord_abs;
  logic [ppz_pkg::GAIN_W-1:0]        p_ext, scaled;
  logic signed [ppz_pkg::SUM_W-1:0]  centre, neg_sum;
  logic [ppz_pkg::SUM_W-1:0]         abs_sum;
  logic signed [ppz_pkg::POS_W-1:0]  trunc;

  always_comb begin
    coord     = axis_r ? coord_y : coord_x;
    coord_abs = coord[31] ? (32'd0 - coord) : coord;
    // Gain 50 on x, 25 on y, built from shifts.
    p_ext  = {{(ppz_pkg::GAIN_W-ppz_pkg::PROD_W){1'b0}}, prod_r};
    scaled = axis_r ? ((p_ext << 4) + (p_ext << 3) + p_ext)
                    : ((p_ext << 5) + (p_ext << 4) + (p_ext << 1));
    centre = axis_r ? $signed({15'd0, center_y, 24'd0})
                    : $signed({15'd0, width, 39'd0});
    // Truncate toward zero.
    neg_sum = -sum_r;
    abs_sum = sum_r[ppz_pkg::SUM_W-1] ? neg_sum : sum_r;
    trunc   = $signed({1'b0, abs_sum[ppz_pkg::SUM_W-1:ppz_pkg::FRAC_SH]});
    if (sum_r[ppz_pkg::SUM_W-1]) begin
      trunc = -trunc;
    end
  end

  // Step sequence: multiply, gain and clamp, add centre, truncate.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    axis_nxt = axis_r;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    prod_nxt = prod_r;
    mag_nxt  = mag_r;
    sum_nxt  = sum_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (start) begin
      busy_nxt = 1'b1;
      axis_nxt = 1'b0;
      step_nxt = 2'd0;
    end else if (busy_r) begin
      step_nxt = step_r + 2'd1;
      case (step_r)
        2'd0: begin
          prod_nxt = inv * coord_abs;
          neg_nxt  = coord[31];
        end
        2'd1: begin
          if (scaled >= (ppz_pkg::GAIN_W'(1) << 60)) begin
            mag_nxt = ppz_pkg::MAG_W'(1) << 60;
          end else begin
            mag_nxt = scaled[ppz_pkg::MAG_W-1:0];
          end
        end
        2'd2: begin
          sum_nxt = neg_r ? (centre - $signed({2'b0, mag_r}))
                          : (centre + $signed({2'b0, mag_r}));
        end
        default: begin
          if (axis_r) begin
            row_nxt  = trunc;
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else begin
            col_nxt  = trunc;
            axis_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    axis_r <= axis_nxt;
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
    prod_r <= prod_nxt;
    mag_r  <= mag_nxt;
    sum_r  <= sum_nxt;
    col_r  <= col_nxt;
    row_r  <= row_nxt;
  end

  assign done = done_r;
  assign col  = col_r;
  assign row  = row_r;

endmodule

@@ design/ppz_depth_mem.sv @@
// Depth store: single-port synchronous memory with a registered read.
// Depends on ppz_pkg.
module ppz_depth_mem (
  input  logic                      clk,
  input  ppz_pkg::mem_req_t         req,
  output logic [ppz_pkg::INV_W-1:0] rdata
);

  logic [ppz_pkg::INV_W-1:0] mem [ppz_pkg::MAX_PIXELS];
  logic [ppz_pkg::INV_W-1:0] rdata_r;

  // Write and registered read at the same address.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata_r <= mem[req.addr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/point_projection_zbuffer.sv @@
// Point projection with depth test: top level, control FSM and configuration.
// Depends on ppz_pkg, ppz_recip, ppz_project and ppz_depth_mem.
// A plot with a positive depth uses the 41-step divider and then the 8 projection steps.
// A clear item sweeps all 8192 words of the depth store at one word a cycle, then gives its result.
// Throughput is one item at a time; the output register holds a result while the next runs.
// After reset the block clears the whole depth store before accepting an item.
module point_projection_zbuffer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // coord_x [31:0], coord_y [63:32], coord_z [95:64]
  input  logic [0:0]  in_tuser,   // op [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_index [12:0], glyph [20:13], colour_out [28:21]
  output logic [0:0]  out_tuser,  // written [0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);

  ppz_pkg::state_t state_r, state_nxt;

  logic [8:0]              width_r, height_r;
  logic [30:0]             offset_r;
  logic [23:0]             centy_r;
  logic signed [4:0]       shade_r;
  logic [7:0]              colour_r;

  logic [ppz_pkg::ADDR_W-1:0] clr_cnt_r;
  logic                       clr_pend_r;
  logic signed [31:0]         x_r, y_r;
  logic [ppz_pkg::CELL_W-1:0] cell_r, cell_nxt;
  logic                       ok_r, ok_nxt;
  logic                       res_wr_r;
  logic                       out_valid_r;
  logic [31:0]                out_data_r;
  logic                       out_user_r;

  logic signed [33:0]         denom;
  logic                       denom_pos;
  logic                       accept, clr_last, out_free, hit;
  logic                       div_start, div_done, proj_start, proj_done, out_load;
  logic [ppz_pkg::INV_W-1:0]  inv, rdata;
  logic signed [ppz_pkg::POS_W-1:0] col, row;
  ppz_pkg::mem_req_t          mem_req;

  assign accept    = in_tvalid && in_tready;
  assign denom     = $signed({{2{in_tdata[95]}}, in_tdata[95:64]}) + $signed({3'b0, offset_r});
  assign denom_pos = !denom[33] && (denom != 34'sd0);
  assign clr_last  = clr_cnt_r == ppz_pkg::ADDR_W'(ppz_pkg::MAX_PIXELS - 1);
  assign out_free  = !out_valid_r || out_tready;
  assign hit       = inv > rdata;

  ppz_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .denom (denom[31:0]),
    .done  (div_done),
    .inv   (inv)
  );

  ppz_project u_project (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (proj_start),
    .inv      (inv),
    .coord_x  (x_r),
    .coord_y  (y_r),
    .width    (width_r),
    .center_y (centy_r),
    .done     (proj_done),
    .col      (col),
    .row      (row)
  );

  ppz_depth_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppz_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = clr_pend_r ? ppz_pkg::ST_OUT : ppz_pkg::ST_IDLE;
        end
      end
      ppz_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0]) begin
            state_nxt = ppz_pkg::ST_CLEAR;
          end else if (denom_pos) begin
            state_nxt = ppz_pkg::ST_DIV;
          end else begin
            state_nxt = ppz_pkg::ST_OUT;
          end
        end
      end
      ppz_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = ppz_pkg::ST_PROJ;
        end
      end
      ppz_pkg::ST_PROJ: begin
        if (proj_done) begin
          state_nxt = ppz_pkg::ST_CELL;
        end
      end
      ppz_pkg::ST_CELL: state_nxt = ppz_pkg::ST_READ;
      ppz_pkg::ST_READ: state_nxt = ok_r ? ppz_pkg::ST_TEST : ppz_pkg::ST_OUT;
      ppz_pkg::ST_TEST: state_nxt = ppz_pkg::ST_OUT;
      ppz_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = ppz_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ppz_pkg::ST_IDLE;
    endcase
  end

  // State outputs and memory access.
  always_comb begin
    in_tready     = 1'b0;
    div_start     = 1'b0;
    proj_start    = 1'b0;
    out_load      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.addr  = cell_r[ppz_pkg::ADDR_W-1:0];
    mem_req.wdata = inv;
    unique case (state_r)
      ppz_pkg::ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_cnt_r;
        mem_req.wdata = '0;
      end
      ppz_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        div_start = in_tvalid && !in_tuser[0] && denom_pos;
      end
      ppz_pkg::ST_DIV:  proj_start = div_done;
      ppz_pkg::ST_TEST: mem_req.we = hit;
      ppz_pkg::ST_OUT:  out_load = out_free;
      default: begin
      end
    endcase
  end

  // Bounds check and cell index from the projected column and row.
  always_comb begin
    cell_nxt = {1'b0, row[7:0]} * {8'd0, width_r} + {9'd0, col[7:0]};
    ok_nxt   = !col[ppz_pkg::POS_W-1] && (col < $signed({15'd0, width_r}))
            && !row[ppz_pkg::POS_W-1] && (row < $signed({15'd0, height_r}))
            && (cell_nxt < ppz_pkg::CELL_W'(ppz_pkg::MAX_PIXELS));
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppz_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      width_r     <= 9'd80;
      height_r    <= 9'd32;
      offset_r    <= 31'd6553600;
      centy_r     <= 24'd1075494;
      shade_r     <= 5'sd0;
      colour_r    <= 8'd7;
    end else begin
      state_r <= state_nxt;
      if (state_r == ppz_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ppz_pkg::ADDR_W'(1);
        if (clr_last) begin
          clr_pend_r <= 1'b0;
        end
      end
      if (accept && in_tuser[0]) begin
        clr_pend_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      // Configuration writes; unknown indexes are ignored.
      if (cfg_we) begin
        case (cfg_index)
          ppz_pkg::REG_WIDTH:  width_r  <= cfg_wdata[8:0];
          ppz_pkg::REG_HEIGHT: height_r <= cfg_wdata[8:0];
          ppz_pkg::REG_OFFSET: offset_r <= cfg_wdata;
          ppz_pkg::REG_CENTY:  centy_r  <= cfg_wdata[23:0];
          ppz_pkg::REG_SHADE:  shade_r  <= $signed(cfg_wdata[4:0]);
          ppz_pkg::REG_COLOUR: colour_r <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r      <= $signed(in_tdata[31:0]);
      y_r      <= $signed(in_tdata[63:32]);
      res_wr_r <= 1'b0;
    end
    if (state_r == ppz_pkg::ST_CELL) begin
      cell_r <= cell_nxt;
      ok_r   <= ok_nxt;
    end
    if (state_r == ppz_pkg::ST_TEST && hit) begin
      res_wr_r <= 1'b1;
    end
    if (out_load) begin
      out_user_r <= res_wr_r;
      out_data_r <= res_wr_r ? {3'b0, colour_r, ppz_pkg::glyph_of(shade_r), cell_r[12:0]}
                             : 32'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ design/ppz_checker.sv @@
// Port-level checker for the point projection block, bound to the top level.
// Depends on point_projection_zbuffer_macros.svh.
`include "point_projection_zbuffer_macros.svh"

module ppz_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // A result that is not taken stays offered.
  `PPZ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)

  // A result without a write carries an all-zero payload.
  `PPZ_ASSERT_NOW(a_nowrite_zero, out_tvalid && !out_tuser[0], out_tdata == 32'd0)

  // Items are worked one at a time: the input closes after each transaction.
  `PPZ_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)

  // The pad bits above the colour field stay zero.
  `PPZ_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[31:29] == 3'd0)

endmodule

bind point_projection_zbuffer ppz_checker u_ppz_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
